FILE: hw/rtl/skvl_pkg.sv
// shared types and constants for the sorted key/value list
`default_nettype none
package skvl_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int RANK_BITS      = 4;
    localparam int CMD_BITS       = 3;

    localparam logic [CMD_BITS-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_POP      = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_REPLACE  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_RETRIEVE = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR    = 3'd4;

    // the operation every cell performs on a chain step
    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_INSERT  = 2'd1,
        CELL_POP     = 2'd2,
        CELL_REPLACE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     first;
        logic     last;
        logic     occ;
        logic     hit;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/skvl_cell.sv
// one entry of the sorted chain: holds a key/value and trades with its neighbors
`default_nettype none
module skvl_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire                        clk,
    input  wire skvl_pkg::cell_ctl_t   ctl,
    input  wire logic [KEY_BITS-1:0]   new_key,
    input  wire logic [VALUE_BITS-1:0] new_value,
    input  wire logic                  left_shift,
    input  wire logic [KEY_BITS-1:0]   left_key,
    input  wire logic [VALUE_BITS-1:0] left_value,
    input  wire logic [KEY_BITS-1:0]   right_key,
    input  wire logic [VALUE_BITS-1:0] right_value,
    output logic                       shift,
    output logic [KEY_BITS-1:0]        key,
    output logic [VALUE_BITS-1:0]      value
);
    import skvl_pkg::*;

    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    // entry sits right of the new one: empty or strictly larger key
    assign shift = !ctl.occ || (key_reg > new_key);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (shift)
                begin
                    if (!ctl.first && left_shift)
                    begin
                        key_next   = left_key;
                        value_next = left_value;
                    end
                    else
                    begin
                        key_next   = new_key;
                        value_next = new_value;
                    end
                end
            end
            CELL_POP:
            begin
                if (!ctl.last)
                begin
                    key_next   = right_key;
                    value_next = right_value;
                end
            end
            CELL_REPLACE:
            begin
                if (ctl.hit)
                begin
                    value_next = new_value;
                end
            end
            default:
            begin
                key_next   = key_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/sorted_key_value_list_top.sv
// top level of the sorted key/value list: cell chain, count and result register
// an accepted request's result is registered in the result register and shown on the m side
// throughput: one request per cycle while s_tready is high; every command finishes in a single chain step
// s_tready drops only while a finished result is held and m_tready is low
// reset clears the count and the result valid; cell contents stay undefined
`default_nettype none
module sorted_key_value_list_top #(
    parameter int CAPACITY   = skvl_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = skvl_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = skvl_pkg::VALUE_BITS_DEF,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int S_W       = ((KEY_BITS + VALUE_BITS + skvl_pkg::RANK_BITS + 7) / 8) * 8,
    localparam int M_W       = ((KEY_BITS + VALUE_BITS + CNT_W + 1 + 7) / 8) * 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [S_W-1:0]                s_tdata,  // key, new_value, rank
    input  wire logic [skvl_pkg::CMD_BITS-1:0] s_tuser,  // command
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [M_W-1:0]                     m_tdata,  // key_out, value_out, count, is_empty
    output logic [0:0]                         m_tuser   // ok
);
    import skvl_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > RANK_BITS) ? CNT_W : RANK_BITS;

    // request fields
    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_value;
    logic [RANK_BITS-1:0]  in_rank;
    logic [CMD_BITS-1:0]   in_cmd;
    logic                  accept;

    assign in_key   = s_tdata[KEY_BITS-1:0];
    assign in_value = s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
    assign in_rank  = s_tdata[KEY_BITS+VALUE_BITS+RANK_BITS-1:KEY_BITS+VALUE_BITS];
    assign in_cmd   = s_tuser;

    logic [CNT_W-1:0] count_reg, count_next;

    // result register, which also decouples the two sides
    logic                  m_valid_reg, m_valid_next;
    logic                  ok_reg, ok_next;
    logic [KEY_BITS-1:0]   key_out_reg, key_out_next;
    logic [VALUE_BITS-1:0] value_out_reg, value_out_next;
    logic [CNT_W-1:0]      m_count_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // chain wiring
    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic                  cell_shift [CAPACITY];

    logic            full;
    logic            rank_ok;
    logic [IDX_W-1:0] rank_idx;
    cell_op_t        op;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign rank_ok  = (CMP_W'(in_rank) < CMP_W'(count_reg));
    assign rank_idx = IDX_W'(in_rank);

    // the whole chain moves together; a failed command leaves it alone
    always_comb
    begin
        op = CELL_HOLD;
        if (accept)
        begin
            case (in_cmd)
                CMD_INSERT:  op = full ? CELL_HOLD : CELL_INSERT;
                CMD_POP:     op = (count_reg != '0) ? CELL_POP : CELL_HOLD;
                CMD_REPLACE: op = rank_ok ? CELL_REPLACE : CELL_HOLD;
                default:     op = CELL_HOLD;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_ctl_t             ctl;
            logic                  l_shift;
            logic [KEY_BITS-1:0]   l_key;
            logic [VALUE_BITS-1:0] l_value;
            logic [KEY_BITS-1:0]   r_key;
            logic [VALUE_BITS-1:0] r_value;

            assign ctl.op    = op;
            assign ctl.first = (gi == 0);
            assign ctl.last  = (gi == CAPACITY - 1);
            assign ctl.occ   = (CNT_W'(gi) < count_reg);
            assign ctl.hit   = (rank_idx == IDX_W'(gi));

            // end cells see their own outputs; the first/last flags mask them
            if (gi == 0)
            begin : g_left_end
                assign l_shift = cell_shift[gi];
                assign l_key   = cell_key[gi];
                assign l_value = cell_value[gi];
            end
            else
            begin : g_left
                assign l_shift = cell_shift[gi-1];
                assign l_key   = cell_key[gi-1];
                assign l_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_right_end
                assign r_key   = cell_key[gi];
                assign r_value = cell_value[gi];
            end
            else
            begin : g_right
                assign r_key   = cell_key[gi+1];
                assign r_value = cell_value[gi+1];
            end

            skvl_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .new_key     (in_key),
                .new_value   (in_value),
                .left_shift  (l_shift),
                .left_key    (l_key),
                .left_value  (l_value),
                .right_key   (r_key),
                .right_value (r_value),
                .shift       (cell_shift[gi]),
                .key         (cell_key[gi]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    // result and count update
    always_comb
    begin
        count_next     = count_reg;
        ok_next        = ok_reg;
        key_out_next   = key_out_reg;
        value_out_next = value_out_reg;
        m_valid_next   = m_valid_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (accept)
        begin
            m_valid_next   = 1'b1;
            ok_next        = 1'b0;
            key_out_next   = '0;
            value_out_next = '0;
            case (in_cmd)
                CMD_INSERT:
                begin
                    if (!full)
                    begin
                        ok_next    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    if (count_reg != '0)
                    begin
                        ok_next        = 1'b1;
                        key_out_next   = cell_key[0];
                        value_out_next = cell_value[0];
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                CMD_REPLACE:
                begin
                    ok_next = rank_ok;
                end
                CMD_RETRIEVE:
                begin
                    if (rank_ok)
                    begin
                        ok_next        = 1'b1;
                        key_out_next   = cell_key[rank_idx];
                        value_out_next = cell_value[rank_idx];
                    end
                end
                CMD_CLEAR:
                begin
                    ok_next    = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        ok_reg        <= ok_next;
        key_out_reg   <= key_out_next;
        value_out_reg <= value_out_next;
        if (accept)
        begin
            m_count_reg <= count_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = ok_reg;
    assign m_tdata    = M_W'({(m_count_reg == '0), m_count_reg, value_out_reg, key_out_reg});

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_count_shown: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (m_count_reg == count_reg) && m_valid_reg)
        else $error("reported count differs from held count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_cmd == CMD_INSERT) && !full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_cmd == CMD_POP) && (count_reg == '0) |=> !ok_reg && (count_reg == '0))
        else $error("pop on empty reported success");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_tready |=> $stable(m_count_reg) && $stable(ok_reg) && m_valid_reg)
        else $error("pending result changed");

endmodule
`default_nettype wire
